FILE: rtl/websocket_frame_deframer_assert.svh
// Assertion macros shared by the deframer modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define WSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked during reset.
`define WSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; used by every module of the block.
package wsd_pkg;

  localparam int unsigned LENGTH_BITS_DEFAULT = 64;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MASK_REQUIRED = 1'd1;
  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd65536;

  // Opcodes
  localparam logic [3:0] OPC_CONT   = 4'h0;
  localparam logic [3:0] OPC_TEXT   = 4'h1;
  localparam logic [3:0] OPC_BINARY = 4'h2;
  localparam logic [3:0] OPC_CLOSE  = 4'h8;
  localparam logic [3:0] OPC_PING   = 4'h9;
  localparam logic [3:0] OPC_PONG   = 4'hA;

  // 7-bit length escapes and byte counts
  localparam logic [6:0] LEN7_EXT16   = 7'd126;
  localparam logic [6:0] LEN7_EXT64   = 7'd127;
  localparam logic [3:0] EXT16_BYTES  = 4'd2;
  localparam logic [3:0] EXT64_BYTES  = 4'd8;
  localparam logic [3:0] KEY_BYTES    = 4'd4;

  typedef enum logic [3:0] {
    ST_OK                = 4'd0,
    ST_RSV               = 4'd1,
    ST_BAD_OPCODE        = 4'd2,
    ST_CONTINUATION      = 4'd3,
    ST_CONTROL_NOT_FINAL = 4'd4,
    ST_DATA_NOT_FINAL    = 4'd5,
    ST_MASK_MISMATCH     = 4'd6,
    ST_LENGTH_MSB        = 4'd7,
    ST_TOO_LARGE         = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  // One queued result: raw byte plus key byte, unmasked in the back end.
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key;
    logic [3:0] opcode;
    logic       last;
    logic       empty;
    status_t    status;
  } wsd_entry_t;

endpackage

FILE: rtl/wsd_fifo.sv
// Small result queue between the header parser and the output stage.
// Depends on wsd_pkg and the assertion macro header.
`include "websocket_frame_deframer_assert.svh"

module wsd_fifo #(
  parameter int unsigned DEPTH = wsd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  wsd_pkg::wsd_entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output wsd_pkg::wsd_entry_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  wsd_pkg::wsd_entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full  = (count == (PTR_W+1)'(DEPTH));
  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `WSD_ASSERT_NOW(a_count_bound, 1'b1, count <= (PTR_W+1)'(DEPTH), "queue count over depth")
  `WSD_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "queue count not raised")

endmodule

FILE: rtl/wsd_front.sv
// Header parser: accepts stream bytes, tracks frame phase, queues results.
// Depends on wsd_pkg and the assertion macro header.
`include "websocket_frame_deframer_assert.svh"

module wsd_front #(
  parameter int unsigned LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic [31:0]         max_payload,
  input  logic                mask_required,
  output logic                push,
  output wsd_pkg::wsd_entry_t push_entry,
  input  logic                full
);

  // Accepted lengths never exceed max_payload, so 32 bits always suffice.
  localparam int unsigned CNT_W = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;

  wsd_pkg::phase_t phase, phase_next;
  logic [3:0]       held_opcode;
  logic             mask_present;
  logic [CNT_W-1:0] len;
  logic             len_over;
  logic             msb_seen;
  logic [3:0]       ext_left;
  logic [31:0]      key_word;
  logic [1:0]       key_index;
  logic             error_latched;

  logic             go;
  logic             has_res;
  logic             hdr_short;
  logic [CNT_W-1:0] ext_len;
  logic             ext_over;
  logic             ext_msb;
  logic [CNT_W-1:0] chk_len;
  logic             chk_over;
  logic             chk_msb;
  logic             chk_zero;
  wsd_pkg::status_t chk_status;
  wsd_pkg::status_t hdr0_status;
  logic             last_ext;

  assign in_ready  = !full;
  assign go        = in_valid && !full && !error_latched;
  assign push      = go && has_res;
  assign hdr_short = in_byte[6:0] < wsd_pkg::LEN7_EXT16;
  assign last_ext  = (ext_left == 4'd1);

  // Length accumulation and limit checks
  always_comb begin
    ext_len   = {len[CNT_W-9:0], in_byte};
    ext_over  = len_over || (len[CNT_W-1 -: 8] != 8'd0);
    ext_msb   = msb_seen || ((ext_left == wsd_pkg::EXT64_BYTES) && in_byte[7]);
    if (phase == wsd_pkg::PH_EXT) begin
      chk_len  = ext_len;
      chk_over = ext_over;
      chk_msb  = ext_msb;
    end else begin
      chk_len  = CNT_W'(in_byte[6:0]);
      chk_over = 1'b0;
      chk_msb  = 1'b0;
    end
    chk_zero = (chk_len == '0);
    if (chk_msb) begin
      chk_status = wsd_pkg::ST_LENGTH_MSB;
    end else if (chk_over || (32'(chk_len) > max_payload)) begin
      chk_status = wsd_pkg::ST_TOO_LARGE;
    end else begin
      chk_status = wsd_pkg::ST_OK;
    end
  end

  // First header byte checks, in priority order
  always_comb begin
    hdr0_status = wsd_pkg::ST_OK;
    if (in_byte[6:4] != 3'd0) begin
      hdr0_status = wsd_pkg::ST_RSV;
    end else begin
      unique case (in_byte[3:0]) inside
        wsd_pkg::OPC_CONT: hdr0_status = wsd_pkg::ST_CONTINUATION;
        wsd_pkg::OPC_TEXT, wsd_pkg::OPC_BINARY: begin
          if (!in_byte[7]) hdr0_status = wsd_pkg::ST_DATA_NOT_FINAL;
        end
        wsd_pkg::OPC_CLOSE, wsd_pkg::OPC_PING, wsd_pkg::OPC_PONG: begin
          if (!in_byte[7]) hdr0_status = wsd_pkg::ST_CONTROL_NOT_FINAL;
        end
        default: hdr0_status = wsd_pkg::ST_BAD_OPCODE;
      endcase
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      wsd_pkg::PH_HDR0: begin
        if (hdr0_status == wsd_pkg::ST_OK) phase_next = wsd_pkg::PH_HDR1;
      end
      wsd_pkg::PH_HDR1: begin
        if (in_byte[7] != mask_required) begin
          phase_next = phase;
        end else if (!hdr_short) begin
          phase_next = wsd_pkg::PH_EXT;
        end else if (chk_status == wsd_pkg::ST_OK) begin
          if (in_byte[7])    phase_next = wsd_pkg::PH_KEY;
          else if (chk_zero) phase_next = wsd_pkg::PH_HDR0;
          else               phase_next = wsd_pkg::PH_DATA;
        end
      end
      wsd_pkg::PH_EXT: begin
        if (last_ext && chk_status == wsd_pkg::ST_OK) begin
          if (mask_present)  phase_next = wsd_pkg::PH_KEY;
          else if (chk_zero) phase_next = wsd_pkg::PH_HDR0;
          else               phase_next = wsd_pkg::PH_DATA;
        end
      end
      wsd_pkg::PH_KEY: begin
        if (last_ext) begin
          phase_next = (len == '0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_DATA;
        end
      end
      wsd_pkg::PH_DATA: begin
        if (len == CNT_W'(1)) phase_next = wsd_pkg::PH_HDR0;
      end
      default: phase_next = wsd_pkg::PH_HDR0;
    endcase
  end

  // Result classification
  always_comb begin
    has_res           = 1'b0;
    push_entry.data   = 8'd0;
    push_entry.key    = 8'd0;
    push_entry.opcode = held_opcode;
    push_entry.last   = 1'b0;
    push_entry.empty  = 1'b0;
    push_entry.status = wsd_pkg::ST_OK;
    unique case (phase)
      wsd_pkg::PH_HDR0: begin
        push_entry.opcode = in_byte[3:0];
        if (hdr0_status != wsd_pkg::ST_OK) begin
          has_res           = 1'b1;
          push_entry.status = hdr0_status;
        end
      end
      wsd_pkg::PH_HDR1: begin
        if (in_byte[7] != mask_required) begin
          has_res           = 1'b1;
          push_entry.status = wsd_pkg::ST_MASK_MISMATCH;
        end else if (hdr_short) begin
          if (chk_status != wsd_pkg::ST_OK) begin
            has_res           = 1'b1;
            push_entry.status = chk_status;
          end else if (!in_byte[7] && chk_zero) begin
            has_res          = 1'b1;
            push_entry.last  = 1'b1;
            push_entry.empty = 1'b1;
          end
        end
      end
      wsd_pkg::PH_EXT: begin
        if (last_ext) begin
          if (chk_status != wsd_pkg::ST_OK) begin
            has_res           = 1'b1;
            push_entry.status = chk_status;
          end else if (!mask_present && chk_zero) begin
            has_res          = 1'b1;
            push_entry.last  = 1'b1;
            push_entry.empty = 1'b1;
          end
        end
      end
      wsd_pkg::PH_KEY: begin
        if (last_ext && len == '0) begin
          has_res          = 1'b1;
          push_entry.last  = 1'b1;
          push_entry.empty = 1'b1;
        end
      end
      wsd_pkg::PH_DATA: begin
        has_res         = 1'b1;
        push_entry.data = in_byte;
        push_entry.key  = key_word[{~key_index, 3'b000} +: 8];
        push_entry.last = (len == CNT_W'(1));
      end
      default: has_res = 1'b0;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= wsd_pkg::PH_HDR0;
      held_opcode   <= 4'd0;
      mask_present  <= 1'b0;
      len_over      <= 1'b0;
      msb_seen      <= 1'b0;
      ext_left      <= 4'd0;
      key_index     <= 2'd0;
      error_latched <= 1'b0;
    end else if (go) begin
      phase <= phase_next;
      if (has_res && push_entry.status != wsd_pkg::ST_OK) begin
        error_latched <= 1'b1;
      end
      unique case (phase)
        wsd_pkg::PH_HDR0: held_opcode <= in_byte[3:0];
        wsd_pkg::PH_HDR1: begin
          mask_present <= in_byte[7];
          key_index    <= 2'd0;
          msb_seen     <= 1'b0;
          len_over     <= 1'b0;
          if (hdr_short) begin
            ext_left <= wsd_pkg::KEY_BYTES;
          end else begin
            ext_left <= (in_byte[6:0] == wsd_pkg::LEN7_EXT64) ? wsd_pkg::EXT64_BYTES
                                                                : wsd_pkg::EXT16_BYTES;
          end
        end
        wsd_pkg::PH_EXT: begin
          len_over <= ext_over;
          msb_seen <= ext_msb;
          ext_left <= last_ext ? wsd_pkg::KEY_BYTES : ext_left - 4'd1;
        end
        wsd_pkg::PH_KEY: begin
          ext_left  <= ext_left - 4'd1;
          key_index <= 2'd0;
        end
        wsd_pkg::PH_DATA: key_index <= key_index + 2'd1;
        default: key_index <= key_index;
      endcase
    end
  end

  // Length and key, no reset needed
  always_ff @(posedge clk) begin
    if (go) begin
      unique case (phase)
        wsd_pkg::PH_HDR1: begin
          key_word <= 32'd0;
          len      <= hdr_short ? CNT_W'(in_byte[6:0]) : '0;
        end
        wsd_pkg::PH_EXT:  len      <= ext_len;
        wsd_pkg::PH_KEY:  key_word <= {key_word[23:0], in_byte};
        wsd_pkg::PH_DATA: len      <= len - CNT_W'(1);
        default:          len      <= len;
      endcase
    end
  end

  `WSD_ASSERT_NOW(a_quiet_after_error, error_latched, !push, "result after latched error")
  `WSD_ASSERT_NEXT(a_error_latches, push && push_entry.status != wsd_pkg::ST_OK, error_latched,
                   "error not latched")

endmodule

FILE: rtl/wsd_back.sv
// Output stage: pops queued results, unmasks the byte, holds the output word.
// Depends on wsd_pkg.
module wsd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  wsd_pkg::wsd_entry_t q_head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic [3:0]          out_opcode,
  output logic                out_last,
  output logic                out_empty,
  output wsd_pkg::status_t    out_status
);

  assign pop = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte   <= q_head.data ^ q_head.key;
      out_opcode <= q_head.opcode;
      out_last   <= q_head.last;
      out_empty  <= q_head.empty;
      out_status <= q_head.status;
    end
  end

endmodule

FILE: rtl/websocket_frame_deframer.sv
// WebSocket frame deframer: one stream byte per clock in, unmasked payload words out.
// Each byte's result word goes through a queue write, then the output register.
// Throughput: 1 byte per cycle; header bytes yield a word only for errors and empty
// frames, and the input stalls only while the result queue (QUEUE_DEPTH words) is full.
// Reset (rst, synchronous): parser back to first header byte, error flag and queue
// cleared, max_payload = 65536, mask_required = 1.
// Depends on wsd_pkg, wsd_fifo, wsd_front, wsd_back.
module websocket_frame_deframer #(
  parameter int unsigned LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEFAULT,
  parameter int unsigned QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // byte stream in
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] in_byte
  // result words out
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // [7:0] payload_byte
  output logic [8:0]                      m_axis_tuser,  // [3:0] frame_opcode,
                                                         // [4] frame_empty, [8:5] status
  output logic                            m_axis_tlast,  // frame_last
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wsd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wsd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [31:0]         max_payload;
  logic                mask_required;

  logic                q_push;
  wsd_pkg::wsd_entry_t q_push_entry;
  logic                q_full;
  logic                q_pop;
  logic                q_valid;
  wsd_pkg::wsd_entry_t q_head;

  logic [3:0]          out_opcode;
  logic                out_empty;
  wsd_pkg::status_t    out_status;

  // Register port: always ready; a write takes effect in the cycle after cfg_valid.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload   <= wsd_pkg::MAX_PAYLOAD_RESET;
      mask_required <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wsd_pkg::REG_MAX_PAYLOAD:   max_payload   <= cfg_data[31:0];
        wsd_pkg::REG_MASK_REQUIRED: mask_required <= cfg_data[0];
        default:                    max_payload   <= max_payload;
      endcase
    end
  end

  // Front end: header parse, length/mask tracking, error detection.
  wsd_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_byte       (s_axis_tdata),
    .max_payload   (max_payload),
    .mask_required (mask_required),
    .push          (q_push),
    .push_entry    (q_push_entry),
    .full          (q_full)
  );

  // Result queue decouples parsing from downstream backpressure.
  wsd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  // Back end: unmask and drive the output register.
  wsd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .pop        (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_byte   (m_axis_tdata),
    .out_opcode (out_opcode),
    .out_last   (m_axis_tlast),
    .out_empty  (out_empty),
    .out_status (out_status)
  );

  assign m_axis_tuser = {out_status, out_empty, out_opcode};

endmodule
